/* design/swm_pkg.sv */
// swm_pkg: shared constants, codes and payload types for the star wildcard matcher.
// No dependencies; used by swm_cell, swm_scan and star_wildcard_matcher_top.
package swm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int NPOS        = MAX_PATTERN + 1;
	localparam int POS_W       = $clog2(NPOS);
	localparam int LVLS        = $clog2(NPOS);

	localparam logic [7:0] STAR_BYTE = 8'h2A;

	localparam logic [1:0] KIND_PAT   = 2'd0;
	localparam logic [1:0] KIND_TEXT  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} req_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} rsp_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic text;     // text byte step
		logic restart;  // end of text: reload star closure of position zero
		logic clear;    // pattern cleared
	} ctl_t;

endpackage

/* design/swm_scan.sv */
// swm_scan: log-depth prefix scan that closes the active set over runs of stars.
// Depends on swm_pkg.
module swm_scan (
	input  logic [swm_pkg::NPOS-1:0] raw,
	input  logic [swm_pkg::NPOS-1:0] prop,
	output logic [swm_pkg::NPOS-1:0] closed
);

	// closed[k] = raw[k] | (closed[k-1] & prop[k]); prop[0] is zero
	logic [swm_pkg::NPOS-1:0] g [swm_pkg::LVLS+1];
	logic [swm_pkg::NPOS-1:0] p [swm_pkg::LVLS+1];

	assign g[0] = raw;
	assign p[0] = prop;

	for (genvar lv = 0; lv < swm_pkg::LVLS; lv++) begin : g_lvl
		localparam int D = 1 << lv;
		for (genvar k = 0; k < swm_pkg::NPOS; k++) begin : g_pos
			if (k >= D) begin : g_comb
				assign g[lv+1][k] = g[lv][k] | (p[lv][k] & g[lv][k-D]);
				assign p[lv+1][k] = p[lv][k] & p[lv][k-D];
			end else begin : g_pass
				assign g[lv+1][k] = g[lv][k];
				assign p[lv+1][k] = p[lv][k];
			end
		end
	end

	assign closed = g[swm_pkg::LVLS];

endmodule

/* design/swm_cell.sv */
// swm_cell: one pattern position: stored byte, valid flag and active bit.
// Depends on swm_pkg.
module swm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  swm_pkg::ctl_t     ctl,
	input  logic              wr_en,
	input  logic [7:0]        ch,
	input  logic              seed,
	input  logic              prev_adv,
	input  logic              prev_grow,
	input  logic              closed,
	output logic              act,
	output logic              prop,
	output logic              adv,
	output logic              grow,
	output logic              raw
);

	logic [7:0] pat_q;
	logic       vld_q;
	logic       act_q;
	logic       is_star;

	assign is_star = (pat_q == swm_pkg::STAR_BYTE);
	assign act     = act_q;
	assign prop    = vld_q & is_star;
	// literal hit hands activity to the next position
	assign adv     = act_q & vld_q & ~is_star & (pat_q == ch);
	// a star appended at an active position opens the next one
	assign grow    = wr_en & (ch == swm_pkg::STAR_BYTE) & act_q;
	assign raw     = ctl.text ? ((act_q & vld_q & is_star) | prev_adv) : seed;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			act_q <= seed;
		end else begin
			if (ctl.clear) begin
				vld_q <= 1'b0;
			end else if (wr_en) begin
				vld_q <= 1'b1;
			end
			priority if (ctl.clear) begin
				act_q <= seed;
			end else if (ctl.text || ctl.restart) begin
				act_q <= closed;
			end else if (prev_grow) begin
				act_q <= 1'b1;
			end
		end
	end

endmodule

/* design/star_wildcard_matcher_top.sv */
// star_wildcard_matcher_top: streamed '*'-only glob matcher built as a row of cells.
// Depends on swm_pkg, swm_cell and swm_scan.
//
//  channel | signals                        | payload          | direction
//  --------+--------------------------------+------------------+----------
//  req     | req_valid, req_ready, req      | swm_pkg::req_t   | into block
//  rsp     | rsp_valid, rsp_ready, rsp      | swm_pkg::rsp_t   | out of block
//
// A new request is taken each cycle, except while req_ready is low.
// The clock period is set by the byte compare in each cell plus the star-closure
// prefix scan across the row (log2 of the position count levels).
// Only end-of-text requests give a response, registered and valid in the cycle after.
// req_ready drops only while a response is held and rsp_ready is low.
// Reset: empty pattern, position zero active, overflow clear, no response.
module star_wildcard_matcher_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  swm_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output swm_pkg::rsp_t  rsp
);

	localparam int MP = swm_pkg::MAX_PATTERN;

	logic [swm_pkg::POS_W-1:0] len_q;
	logic                      ovf_q;
	logic                      act_top_q;   // position just past a full pattern
	logic                      rsp_valid_q;
	swm_pkg::rsp_t             rsp_q;

	logic                      acc;
	logic                      full;
	logic                      is_pat;
	logic                      is_end;
	swm_pkg::ctl_t             ctl;

	logic [MP-1:0]             wr_en;
	logic [MP-1:0]             act;
	logic [MP-1:0]             prop_c;
	logic [MP-1:0]             adv;
	logic [MP-1:0]             grow;
	logic [MP-1:0]             raw_c;

	logic [swm_pkg::NPOS-1:0]  raw;
	logic [swm_pkg::NPOS-1:0]  prop;
	logic [swm_pkg::NPOS-1:0]  closed;
	logic [swm_pkg::NPOS-1:0]  act_vec;

	assign req_ready = ~rsp_valid_q | rsp_ready;
	assign acc       = req_valid & req_ready;
	assign full      = (len_q == swm_pkg::POS_W'(MP));

	// decode the request kind into per-cycle commands
	always_comb begin
		is_pat      = 1'b0;
		is_end      = 1'b0;
		ctl.text    = 1'b0;
		ctl.restart = 1'b0;
		ctl.clear   = 1'b0;
		unique case (req.kind)
			swm_pkg::KIND_PAT:   is_pat      = acc;
			swm_pkg::KIND_TEXT:  ctl.text    = acc;
			swm_pkg::KIND_END: begin
				is_end      = acc;
				ctl.restart = acc;
			end
			swm_pkg::KIND_CLEAR: ctl.clear   = acc;
			default: ;
		endcase
	end

	// cell row: each cell passes its literal hit and star growth to the next
	for (genvar i = 0; i < MP; i++) begin : g_cell
		assign wr_en[i] = is_pat & ~full & (len_q == swm_pkg::POS_W'(i));

		swm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wr_en     (wr_en[i]),
			.ch        (req.ch),
			.seed      ((i == 0) ? 1'b1 : 1'b0),
			.prev_adv  ((i == 0) ? 1'b0 : adv[(i == 0) ? 0 : i-1]),
			.prev_grow ((i == 0) ? 1'b0 : grow[(i == 0) ? 0 : i-1]),
			.closed    (closed[i]),
			.act       (act[i]),
			.prop      (prop_c[i]),
			.adv       (adv[i]),
			.grow      (grow[i]),
			.raw       (raw_c[i])
		);
	end

	// last position has no pattern byte; it only receives from the last cell
	assign raw     = {(ctl.text & adv[MP-1]), raw_c};
	assign prop    = {prop_c, 1'b0};
	assign act_vec = {act_top_q, act};

	swm_scan u_scan (
		.raw    (raw),
		.prop   (prop),
		.closed (closed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			act_top_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (is_pat) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + 1'b1;
				end
			end

			priority if (ctl.clear) begin
				act_top_q <= 1'b0;
			end else if (ctl.text || ctl.restart) begin
				act_top_q <= closed[MP];
			end else if (grow[MP-1]) begin
				act_top_q <= 1'b1;
			end

			if (is_end) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// stored set is kept star-closed, so the match is the bit at the length
	always_ff @(posedge clk) begin
		if (is_end) begin
			rsp_q.matched          <= act_vec[len_q];
			rsp_q.pattern_overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* tb/sv/star_wildcard_matcher_top_tb.sv */
// star_wildcard_matcher_top_tb: self-checking bench for the streamed '*' glob matcher.
// Depends on swm_pkg and star_wildcard_matcher_top; a scoreboard class predicts each
// end-of-text response from its own copy of the pattern and the active position set.
`timescale 1ns / 1ps

module star_wildcard_matcher_top_tb;

	import swm_pkg::*;

	localparam int CYCLE_LIMIT  = 200000; // far above the slowest legal run
	localparam int RAND_ITEMS   = 400;    // random requests to send
	localparam int DRAIN_CYCLES = 10;     // the response to END comes from a register
	localparam int IDLE_PCT     = 16;

	// Scoreboard: tracks pattern, live positions and overflow; queues expected
	// responses in request order and compares each response against the oldest.
	class swm_scoreboard;
		logic [7:0]      pat_mem [MAX_PATTERN];
		int unsigned     pat_len;
		logic [NPOS-1:0] live_pos;
		logic            ovf;
		rsp_t            pending[$];
		int              errors;

		function new();
			pat_len  = 0;
			live_pos = NPOS'(1);
			ovf      = 1'b0;
			errors   = 0;
		endfunction

		// a star at a live position makes the next position live as well
		function logic [NPOS-1:0] close_stars(logic [NPOS-1:0] s);
			for (int i = 0; i < pat_len; i++) begin
				if (s[i] && pat_mem[i] == STAR_BYTE)
					s[i+1] = 1'b1;
			end
			return s;
		endfunction

		function void note_req(req_t r);
			logic [NPOS-1:0] cur;
			logic [NPOS-1:0] nxt;
			rsp_t            exp_rsp;
			case (r.kind)
				KIND_PAT: begin
					if (pat_len < MAX_PATTERN) begin
						pat_mem[pat_len] = r.ch;
						pat_len++;
					end else begin
						ovf = 1'b1;
					end
				end
				KIND_TEXT: begin
					cur = close_stars(live_pos);
					nxt = '0;
					for (int i = 0; i < pat_len; i++) begin
						if (cur[i]) begin
							if (pat_mem[i] == STAR_BYTE)
								nxt[i] = 1'b1;
							else if (pat_mem[i] == r.ch)
								nxt[i+1] = 1'b1;
						end
					end
					live_pos = nxt;
				end
				KIND_END: begin
					cur = close_stars(live_pos);
					exp_rsp.matched          = cur[pat_len];
					exp_rsp.pattern_overflow = ovf;
					pending.push_back(exp_rsp);
					live_pos = NPOS'(1);
				end
				default: begin
					pat_len  = 0;
					ovf      = 1'b0;
					live_pos = NPOS'(1);
				end
			endcase
		endfunction

		function void check_rsp(rsp_t r);
			rsp_t exp_rsp;
			if (pending.size() == 0) begin
				$error("unexpected response: matched=%0b pattern_overflow=%0b",
					r.matched, r.pattern_overflow);
				errors++;
				return;
			end
			exp_rsp = pending.pop_front();
			if (r.matched !== exp_rsp.matched) begin
				$error("matched: expected %0b, actual %0b", exp_rsp.matched, r.matched);
				errors++;
			end
			if (r.pattern_overflow !== exp_rsp.pattern_overflow) begin
				$error("pattern_overflow: expected %0b, actual %0b",
					exp_rsp.pattern_overflow, r.pattern_overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	swm_scoreboard sb;
	int unsigned   req_count = 0;
	int unsigned   cycles    = 0;
	bit            quiet     = 1'b0; // set during the stretch with no idling

	star_wildcard_matcher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Response side: check at the accepting edge, then pick the next ready level.
	// Values read right after the edge are the ones the edge saw.
	initial begin
		sb = new();
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready)
				sb.check_rsp(rsp);
			if (!arst_n)
				rsp_ready <= 1'b0;
			else
				rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Send one request. Valid stays up between back-to-back requests; it only
	// drops for random idle cycles and after the last request. The request is logged at the edge that takes it.
	task automatic send_req(logic [1:0] kind, logic [7:0] ch);
		req_t r;
		r.kind = kind;
		r.ch   = ch;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_req(r);
		req_count++;
	endtask

	// Small alphabet so that literals and stars line up often.
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)      return "a";
		else if (r < 50) return "b";
		else if (r < 65) return STAR_BYTE;
		else if (r < 75) return "A";
		else             return 8'($urandom_range(0, 255));
	endfunction

	// One well-formed sequence: clear (usually), pattern, text (mostly derived from
	// the pattern, sometimes damaged), end of text.
	task automatic run_match_sequence();
		logic [7:0]  pat_q[$];
		logic [7:0]  txt_q[$];
		int unsigned plen;
		int unsigned r;
		// most patterns short; a few run past the pattern store to overflow
		r = $urandom_range(0, 99);
		if (r < 85)      plen = $urandom_range(0, 6);
		else if (r < 95) plen = $urandom_range(7, 31);
		else             plen = $urandom_range(32, 36);
		for (int i = 0; i < plen; i++)
			pat_q.push_back(pick_byte());
		if ($urandom_range(0, 99) < 60) begin
			foreach (pat_q[i]) begin
				if (pat_q[i] == STAR_BYTE)
					repeat ($urandom_range(0, 3)) txt_q.push_back(pick_byte());
				else
					txt_q.push_back(pat_q[i]);
			end
			r = $urandom_range(0, 99);
			if (txt_q.size() > 0 && r < 25)
				txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_byte();
			else if (txt_q.size() > 0 && r < 35)
				void'(txt_q.pop_back());
			else if (r < 40)
				txt_q.push_back(pick_byte());
		end else begin
			repeat ($urandom_range(0, 6)) txt_q.push_back(pick_byte());
		end
		// usually start from an empty pattern; sometimes keep the old one
		if ($urandom_range(0, 99) < 90)
			send_req(KIND_CLEAR, 8'($urandom_range(0, 255)));
		foreach (pat_q[i])
			send_req(KIND_PAT, pat_q[i]);
		foreach (txt_q[i]) begin
			// pattern grows while text is streaming
			if ($urandom_range(0, 99) < 4)
				send_req(KIND_PAT, pick_byte());
			send_req(KIND_TEXT, txt_q[i]);
		end
		send_req(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	// Unstructured requests: any kind, any byte.
	task automatic run_noise();
		repeat ($urandom_range(1, 6))
			send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int unsigned rand_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern, empty text: match
		send_req(KIND_END, 8'h00);
		// empty pattern, non-empty text: no match
		send_req(KIND_TEXT, 8'hFF);
		send_req(KIND_END, 8'hFF);
		// all-star pattern, empty text, then a text star taken as a plain byte
		send_req(KIND_PAT, STAR_BYTE);
		send_req(KIND_PAT, STAR_BYTE);
		send_req(KIND_END, 8'h00);
		send_req(KIND_TEXT, STAR_BYTE);
		send_req(KIND_END, 8'h00);
		// literal-star-literal, case kept
		send_req(KIND_CLEAR, 8'hFF);
		send_req(KIND_PAT, "a");
		send_req(KIND_PAT, STAR_BYTE);
		send_req(KIND_PAT, "B");
		send_req(KIND_TEXT, "a");
		send_req(KIND_TEXT, "x");
		send_req(KIND_TEXT, "B");
		send_req(KIND_END, 8'h00);
		send_req(KIND_TEXT, "a");
		send_req(KIND_TEXT, "b");
		send_req(KIND_END, 8'h00);
		// byte zero and byte extremes, pattern grown during text
		send_req(KIND_CLEAR, 8'h00);
		send_req(KIND_PAT, 8'h00);
		send_req(KIND_PAT, 8'hFF);
		send_req(KIND_TEXT, 8'h00);
		send_req(KIND_PAT, 8'h01);
		send_req(KIND_TEXT, 8'hFF);
		send_req(KIND_TEXT, 8'h01);
		send_req(KIND_END, 8'hFF);
		// text star against a pattern with no star
		send_req(KIND_TEXT, STAR_BYTE);
		send_req(KIND_END, 8'h00);

		rand_start = req_count;
		while (req_count - rand_start < RAND_ITEMS) begin
			quiet = (req_count - rand_start >= 150) && (req_count - rand_start < 250);
			if ($urandom_range(0, 99) < 85)
				run_match_sequence();
			else
				run_noise();
		end
		quiet = 1'b0;
		req_valid <= 1'b0;

		// drain: every expected response back, then a DRAIN_CYCLES wait for strays
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
